// ===== sv/bsrt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the beacon spot ring tracker: sizes, band edges, codes and word types.
// Depends on nothing; every other file in the project imports it.

package bsrt_pkg;

  localparam int BEACON_COUNT = 18;
  localparam int BAND_COUNT   = 5;
  localparam int QUEUE_DEPTH  = 5;
  localparam int TIME_BITS    = 32;
  localparam int EDGE_COUNT   = 5;
  localparam int MASK_W       = 18;

  localparam int PAIR_COUNT  = BEACON_COUNT * BAND_COUNT;
  localparam int HEARD_DEPTH = PAIR_COUNT * QUEUE_DEPTH;

  localparam int BAND_W   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam int BEACON_W = (BEACON_COUNT > 1) ? $clog2(BEACON_COUNT) : 1;
  localparam int SLOT_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int PAIR_W   = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int HADDR_W  = (HEARD_DEPTH > 1) ? $clog2(HEARD_DEPTH) : 1;
  localparam int EDGE_W   = 20;

  localparam logic [EDGE_W-1:0] BAND_EDGE [EDGE_COUNT] = '{
    20'd141000, 20'd181100, 20'd211500, 20'd249300, 20'd282000
  };

  localparam logic [15:0] WINDOW_RESET = 16'd300;
  localparam logic [9:0]  MARGIN_RESET = 10'd100;

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_MARGIN = 2'd1
  } bsrt_reg_t;

  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_OVERWRITE = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_IGNORED   = 3'd3,
    ST_STEP      = 3'd4
  } bsrt_status_t;

  typedef struct packed {
    logic        mode;
    logic [4:0]  beacon_index;
    logic [18:0] frequency_tenths_khz;
    logic        spotter_accepted;
    logic [31:0] time_now;
  } bsrt_in_t;

  typedef struct packed {
    bsrt_status_t status;
    logic [2:0]   band_shown;
    logic [17:0]  lit_mask;
  } bsrt_out_t;

  typedef struct packed {
    logic              hit;
    logic [BAND_W-1:0] band;
  } bsrt_bin_t;

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
  } bsrt_meta_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

  function automatic logic [HADDR_W-1:0] heard_addr(input logic [PAIR_W-1:0] pair,
                                                    input logic [SLOT_W-1:0] slot);
    return HADDR_W'(pair) * HADDR_W'(QUEUE_DEPTH) + HADDR_W'(slot);
  endfunction

endpackage

// ===== sv/bsrt_band_bin.sv =====
`timescale 1ns / 1ps
// Band binning: places a frequency in the first band whose upper edge plus margin lies above it.
// Depends on bsrt_pkg for the edge table and the result type.

module bsrt_band_bin
  import bsrt_pkg::*;
(
  input  logic [18:0] frequency,
  input  logic [9:0]  margin,
  output bsrt_bin_t   result
);

  always_comb begin
    result = '0;
    for (int i = EDGE_COUNT - 1; i >= 0; i--) begin
      if ({1'b0, frequency} < BAND_EDGE[i] + EDGE_W'(margin)) begin
        result.hit  = (i < BAND_COUNT);
        result.band = BAND_W'(i);
      end
    end
  end

endmodule

// ===== sv/beacon_spot_ring_tracker_unit.sv =====
`timescale 1ns / 1ps
// Top level of the beacon spot ring tracker: queue state in two memories and the control sequencer.
// Depends on bsrt_pkg and bsrt_band_bin.
//
//   channel | signals                            | role
//   --------+------------------------------------+--------------------------------
//   input   | in_valid, in_stall, in_word        | spot or step word in
//   output  | out_valid, out_stall, out_word     | one result word per input word
//   config  | cfg_valid, cfg_ready, cfg_index,   | register writes, always ready
//           | cfg_data                           |
//
// A stored spot goes through S_BIN, S_SPOT_RMW and S_OUT before its result is raised, an ignored or
// unmatched one from S_BIN straight to S_OUT; the metadata memory read sets that.
// A step passes S_STEP_META for each beacon; one with a non-empty queue also passes S_STEP_HEAD
// and reads its entries one by one in S_STEP_SCAN, and S_OUT makes the hand-over; the single read
// port of the time memory sets that.
// Reset is synchronous and clears the empty flags, so no clearing pass is needed.
// A new word is taken while a finished result still waits in the output register.

module beacon_spot_ring_tracker_unit
  import bsrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  bsrt_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output bsrt_out_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIN,
    S_SPOT_RMW,
    S_STEP_META,
    S_STEP_HEAD,
    S_STEP_SCAN,
    S_OUT
  } state_t;

  state_t              state;
  bsrt_in_t            item;
  bsrt_out_t           res;
  logic [15:0]         window;
  logic [9:0]          margin;
  logic [BAND_W-1:0]   active_band;
  logic [BAND_W-1:0]   step_band;
  logic [BEACON_W-1:0] beacon_cnt;
  logic [PAIR_W-1:0]   pair;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   tail_stop;
  logic [MASK_W-1:0]   mask;
  logic [PAIR_COUNT-1:0] nonempty;

  bsrt_meta_t          meta_mem [PAIR_COUNT];
  bsrt_meta_t          meta_rd;
  logic [TIME_BITS-1:0] heard_mem [HEARD_DEPTH];
  logic [TIME_BITS-1:0] heard_rd;

  bsrt_bin_t           bin;
  logic                spot_ok;
  logic [PAIR_W-1:0]   pair_spot;
  logic [PAIR_W-1:0]   pair_step;
  bsrt_meta_t          meta_new;
  bsrt_status_t        spot_status;
  logic [SLOT_W-1:0]   tail_inc;
  logic [TIME_BITS-1:0] now;
  logic                recent;
  logic                scan_done;
  logic                last_beacon;
  logic [MASK_W-1:0]   mask_hit;
  logic [BAND_W-1:0]   band_inc;
  logic                meta_re;
  logic [PAIR_W-1:0]   meta_raddr;
  logic                heard_re;
  logic [HADDR_W-1:0]  heard_raddr;
  logic                rmw;
  logic [HADDR_W-1:0]  heard_waddr;
  logic                out_free;

  bsrt_band_bin u_bin (
    .frequency (item.frequency_tenths_khz),
    .margin    (margin),
    .result    (bin)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
      margin <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW: window <= cfg_data;
        REG_MARGIN: margin <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    spot_ok   = ({1'b0, item.beacon_index} < 6'(BEACON_COUNT)) && item.spotter_accepted;
    pair_spot = PAIR_W'(item.beacon_index) * PAIR_W'(BAND_COUNT) + PAIR_W'(bin.band);
    pair_step = PAIR_W'(beacon_cnt) * PAIR_W'(BAND_COUNT) + PAIR_W'(step_band);

    tail_inc    = next_slot(meta_rd.tail);
    meta_new    = meta_rd;
    spot_status = ST_STORED;
    if (!nonempty[pair]) begin
      meta_new = '0;
    end else begin
      if (tail_inc == meta_rd.head) begin
        meta_new.head = next_slot(meta_rd.head);
        spot_status   = ST_OVERWRITE;
      end
      meta_new.tail = tail_inc;
    end

    now         = item.time_now[TIME_BITS-1:0];
    recent      = (heard_rd > now) || ((now - heard_rd) < TIME_BITS'(window));
    scan_done   = recent || (slot == tail_stop);
    last_beacon = (beacon_cnt == BEACON_W'(BEACON_COUNT - 1));
    mask_hit    = mask | (MASK_W'(1) << beacon_cnt);
    band_inc    = (step_band == BAND_W'(BAND_COUNT - 1)) ? '0 : step_band + BAND_W'(1);

    meta_re     = 1'b0;
    meta_raddr  = pair_step;
    heard_re    = 1'b0;
    heard_raddr = heard_addr(pair, next_slot(slot));
    unique case (state)
      S_BIN: begin
        meta_re    = spot_ok && bin.hit;
        meta_raddr = pair_spot;
      end
      S_STEP_META: begin
        meta_re = nonempty[pair_step];
      end
      S_STEP_HEAD: begin
        heard_re    = 1'b1;
        heard_raddr = heard_addr(pair, meta_rd.head);
      end
      S_STEP_SCAN: begin
        heard_re = !scan_done;
      end
      default: ;
    endcase

    rmw         = (state == S_SPOT_RMW);
    heard_waddr = heard_addr(pair, meta_new.tail);
  end

  always_ff @(posedge clk) begin
    if (rmw) begin
      meta_mem[pair] <= meta_new;
    end
    if (meta_re) begin
      meta_rd <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rmw) begin
      heard_mem[heard_waddr] <= now;
    end
    if (heard_re) begin
      heard_rd <= heard_mem[heard_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      active_band <= '0;
      nonempty    <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_word;
            beacon_cnt <= '0;
            mask       <= '0;
            step_band  <= (active_band >= BAND_W'(BAND_COUNT)) ? '0 : active_band;
            state      <= in_word.mode ? S_STEP_META : S_BIN;
          end
        end
        S_BIN: begin
          res.band_shown <= '0;
          res.lit_mask   <= '0;
          if (!spot_ok) begin
            res.status <= ST_IGNORED;
            state      <= S_OUT;
          end else if (!bin.hit) begin
            res.status <= ST_UNMATCHED;
            state      <= S_OUT;
          end else begin
            pair  <= pair_spot;
            state <= S_SPOT_RMW;
          end
        end
        S_SPOT_RMW: begin
          nonempty[pair] <= 1'b1;
          res.status     <= spot_status;
          state          <= S_OUT;
        end
        S_STEP_META: begin
          pair <= pair_step;
          if (nonempty[pair_step]) begin
            state <= S_STEP_HEAD;
          end else if (last_beacon) begin
            res.status     <= ST_STEP;
            res.band_shown <= 3'(step_band);
            res.lit_mask   <= mask;
            active_band    <= band_inc;
            state          <= S_OUT;
          end else begin
            beacon_cnt <= beacon_cnt + BEACON_W'(1);
          end
        end
        S_STEP_HEAD: begin
          slot      <= meta_rd.head;
          tail_stop <= meta_rd.tail;
          state     <= S_STEP_SCAN;
        end
        S_STEP_SCAN: begin
          if (scan_done) begin
            if (recent) begin
              mask <= mask_hit;
            end
            if (last_beacon) begin
              res.status     <= ST_STEP;
              res.band_shown <= 3'(step_band);
              res.lit_mask   <= recent ? mask_hit : mask;
              active_band    <= band_inc;
              state          <= S_OUT;
            end else begin
              beacon_cnt <= beacon_cnt + BEACON_W'(1);
              state      <= S_STEP_META;
            end
          end else begin
            slot <= next_slot(slot);
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_word  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is still being processed");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result word raised outside the output hand-over");

  a_step_band: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status == ST_STEP) |-> (out_word.band_shown < 3'(BAND_COUNT)))
    else $error("step result shows a band that does not exist");

  a_spot_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.status != ST_STEP)
      |-> (out_word.band_shown == '0 && out_word.lit_mask == '0))
    else $error("spot result carries a band or a mask");
`endif

endmodule

// ===== dv/bsrt_checker.sv =====
`timescale 1ns / 1ps
// Checker for the beacon spot ring tracker: watches the three channels, predicts each result
// word from its own copy of the queues and registers, and counts mismatches. Depends on bsrt_pkg.

module bsrt_checker
  import bsrt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  bsrt_in_t    in_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  bsrt_out_t   out_word,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [31:0]       heard [PAIR_COUNT][QUEUE_DEPTH];
  logic [SLOT_W-1:0] oldest_slot [PAIR_COUNT];
  logic [SLOT_W-1:0] newest_slot [PAIR_COUNT];
  logic              filled [PAIR_COUNT];
  int                shown_band;
  logic [15:0]       window;
  logic [9:0]        margin;
  bsrt_out_t         awaited [$];
  int                errs;

  function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] s);
    return (int'(s) == QUEUE_DEPTH - 1) ? '0 : s + 1'b1;
  endfunction

  function automatic int band_of(input logic [18:0] f);
    for (int i = 0; i < EDGE_COUNT; i++) begin
      if (int'(f) < int'(BAND_EDGE[i]) + int'(margin)) begin
        return (i < BAND_COUNT) ? i : -1;
      end
    end
    return -1;
  endfunction

  function automatic bit pair_lit(input int p, input logic [31:0] now);
    logic [SLOT_W-1:0] s;
    logic [31:0]       h;
    int                n;
    if (!filled[p]) begin
      return 1'b0;
    end
    n = (int'(newest_slot[p]) + QUEUE_DEPTH - int'(oldest_slot[p])) % QUEUE_DEPTH + 1;
    s = oldest_slot[p];
    for (int k = 0; k < n; k++) begin
      h = heard[p][s];
      if (now < h || (now - h) < {16'd0, window}) begin
        return 1'b1;
      end
      s = wrap_slot(s);
    end
    return 1'b0;
  endfunction

  function automatic bsrt_out_t apply_word(input bsrt_in_t w);
    bsrt_out_t r;
    int        band;
    int        p;
    r.status = ST_STORED;
    r.band_shown = 3'd0;
    r.lit_mask = '0;
    if (w.mode) begin
      band = (shown_band >= BAND_COUNT) ? 0 : shown_band;
      for (int b = 0; b < BEACON_COUNT; b++) begin
        if (pair_lit(b * BAND_COUNT + band, w.time_now) && b < MASK_W) begin
          r.lit_mask[b] = 1'b1;
        end
      end
      r.status = ST_STEP;
      r.band_shown = 3'(band);
      shown_band = (band + 1) % BAND_COUNT;
    end else if (int'(w.beacon_index) >= BEACON_COUNT || !w.spotter_accepted) begin
      r.status = ST_IGNORED;
    end else begin
      band = band_of(w.frequency_tenths_khz);
      if (band < 0) begin
        r.status = ST_UNMATCHED;
      end else begin
        p = int'(w.beacon_index) * BAND_COUNT + band;
        if (!filled[p]) begin
          oldest_slot[p] = '0;
          newest_slot[p] = '0;
          filled[p] = 1'b1;
        end else begin
          if (wrap_slot(newest_slot[p]) == oldest_slot[p]) begin
            oldest_slot[p] = wrap_slot(oldest_slot[p]);
            r.status = ST_OVERWRITE;
          end
          newest_slot[p] = wrap_slot(newest_slot[p]);
        end
        heard[p][newest_slot[p]] = w.time_now;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    bsrt_out_t want;
    if (rst) begin
      for (int p = 0; p < PAIR_COUNT; p++) begin
        filled[p] = 1'b0;
        oldest_slot[p] = '0;
        newest_slot[p] = '0;
      end
      shown_band = 0;
      window = WINDOW_RESET;
      margin = MARGIN_RESET;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WINDOW) begin
          window = cfg_data;
        end else if (cfg_index == REG_MARGIN) begin
          margin = cfg_data[9:0];
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $display("%0t: result word with nothing expected, actual status %0d band %0d mask %h",
                   $time, out_word.status, out_word.band_shown, out_word.lit_mask);
          errs++;
        end else begin
          want = awaited.pop_front();
          if (out_word.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_word.status);
            errs++;
          end
          if (out_word.band_shown !== want.band_shown) begin
            $display("%0t: band_shown mismatch, expected %0d, actual %0d",
                     $time, want.band_shown, out_word.band_shown);
            errs++;
          end
          if (out_word.lit_mask !== want.lit_mask) begin
            $display("%0t: lit_mask mismatch, expected %h, actual %h",
                     $time, want.lit_mask, out_word.lit_mask);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited.push_back(apply_word(in_word));
      end
    end
    pending <= awaited.size();
    fail_count <= errs;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the beacon spot ring tracker testbench: clock, reset, spot and step stimulus, register
// writes and the verdict. Depends on bsrt_pkg, beacon_spot_ring_tracker_unit and bsrt_checker.

module tb_top;
  import bsrt_pkg::*;

  localparam bit MODE_SPOT     = 1'b0;
  localparam bit MODE_STEP     = 1'b1;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 500;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 230;
  localparam int FREQ_TOP      = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bsrt_in_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bsrt_out_t   out_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_asked = 0;
  int          holds_given = 0;
  int          hold_left = 0;
  logic [9:0]  margin_now = MARGIN_RESET;
  logic [31:0] now_s = '0;

  beacon_spot_ring_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bsrt_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("beacon_spot_ring_tracker_unit regression: fail");
      $finish;
    end
  end

  // The receiver either serves a long hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_given != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      holds_given <= holds_given + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic bsrt_in_t spot_word(input int beacon, input int freq, input bit ok,
                                         input logic [31:0] t);
    bsrt_in_t w;
    w.mode = MODE_SPOT;
    w.beacon_index = 5'(beacon);
    w.frequency_tenths_khz = 19'(freq);
    w.spotter_accepted = ok;
    w.time_now = t;
    return w;
  endfunction

  function automatic bsrt_in_t step_word(input logic [31:0] t);
    bsrt_in_t w;
    w.mode = MODE_STEP;
    w.beacon_index = 5'($urandom);
    w.frequency_tenths_khz = 19'($urandom_range(0, FREQ_TOP));
    w.spotter_accepted = 1'($urandom);
    w.time_now = t;
    return w;
  endfunction

  function automatic bsrt_in_t random_word();
    int pick;
    int beacon;
    int freq;
    pick = $urandom_range(99);
    if (pick < 4) begin
      now_s = $urandom;
    end else if (pick < 10) begin
      now_s = now_s - $urandom_range(1, 200);
    end else begin
      now_s = now_s + $urandom_range(0, 60);
    end
    if ($urandom_range(99) < 25) begin
      return step_word(now_s);
    end
    pick = $urandom_range(99);
    if (pick < 70) begin
      beacon = $urandom_range(0, 3);
    end else if (pick < 90) begin
      beacon = $urandom_range(0, BEACON_COUNT - 1);
    end else begin
      beacon = $urandom_range(BEACON_COUNT, 31);
    end
    if ($urandom_range(99) < 55) begin
      freq = int'(BAND_EDGE[$urandom_range(0, EDGE_COUNT - 1)]) + int'(margin_now)
             + int'($urandom_range(0, 600)) - 300;
      if (freq > FREQ_TOP) begin
        freq = FREQ_TOP;
      end
    end else begin
      freq = $urandom_range(0, FREQ_TOP);
    end
    return spot_word(beacon, freq, $urandom_range(99) < 92, now_s);
  endfunction

  task automatic send_word(input bsrt_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] win, input logic [9:0] mar);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data <= win;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_MARGIN;
    cfg_data <= {6'd0, mar};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    margin_now = mar;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Band edges, ignored and unmatched spots, overwrite of the oldest and a full band round.
    send_word(step_word(32'd0));
    send_word(spot_word(0, 0, 1'b1, 32'd0));
    send_word(spot_word(17, 141099, 1'b1, 32'd100));
    send_word(spot_word(17, 141100, 1'b1, 32'd100));
    send_word(spot_word(3, 282099, 1'b1, 32'hFFFF_FFFF));
    send_word(spot_word(3, 282100, 1'b1, 32'd5));
    send_word(spot_word(3, FREQ_TOP, 1'b1, 32'd5));
    send_word(spot_word(BEACON_COUNT, 150000, 1'b1, 32'd5));
    send_word(spot_word(31, FREQ_TOP, 1'b1, 32'd5));
    send_word(spot_word(5, 150000, 1'b0, 32'd5));
    for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
      send_word(spot_word(9, 200000, 1'b1, 32'd1000 + i));
    end
    send_word(step_word(32'd299));
    send_word(step_word(32'd400));
    send_word(step_word(32'd1004));
    send_word(step_word(32'd10));
    send_word(step_word(32'd0));
    send_word(step_word(32'd300));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          set_regs(16'd1, 10'd0);
        end
        1: begin
          set_regs(16'hFFFF, 10'd1000);
        end
        2: begin
          set_regs(16'd0, 10'd500);
        end
        3: begin
          set_regs(WINDOW_RESET, MARGIN_RESET);
        end
        4: begin
          set_regs(16'($urandom_range(1, 1200)), 10'($urandom_range(0, 1000)));
        end
        default: begin
          set_regs(16'($urandom), 10'($urandom_range(0, 1000)));
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 69;
      end else if (ph < 4) begin
        send_idle_pct = 69;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 10) begin
          holds_asked = holds_asked + 1;
        end
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          drain();
        end
        send_word(random_word());
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("beacon_spot_ring_tracker_unit regression: pass");
    end else begin
      $display("beacon_spot_ring_tracker_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== beacon_spot_ring_tracker_unit.f =====
sv/bsrt_pkg.sv
sv/bsrt_band_bin.sv
sv/beacon_spot_ring_tracker_unit.sv
dv/bsrt_checker.sv
dv/tb_top.sv
